// ----- sv/pidsr_pkg.sv -----
// Shared types and constants for the PID speed regulator with anti-windup.
// Holds the register map, fixed-point constants, controller states and the
// command/status structs between controller and datapath. No dependencies.
package pidsr_pkg;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;
    localparam int GAIN_W      = 16;
    localparam int LIMIT_W     = 15;

    localparam logic [CFG_INDEX_W-1:0] REG_PROP_GAIN     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_INTEG_GAIN    = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_DERIV_GAIN    = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKCALC_GAIN = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_SAMPLE_PERIOD = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_OUT_LIMIT     = 3'd5;

    localparam logic [GAIN_W-1:0]  RST_PROP_GAIN     = 16'd4096;
    localparam logic [GAIN_W-1:0]  RST_INTEG_GAIN    = 16'd4096;
    localparam logic [GAIN_W-1:0]  RST_DERIV_GAIN    = 16'd0;
    localparam logic [GAIN_W-1:0]  RST_BACKCALC_GAIN = 16'd4096;
    localparam logic [GAIN_W-1:0]  RST_SAMPLE_PERIOD = 16'd65;
    localparam logic [LIMIT_W-1:0] RST_OUT_LIMIT     = 15'd32767;

    // Fixed-point scaling.
    localparam int GAIN_FRAC   = 12;  // Q4.12 gains
    localparam int INTEG_FRAC  = 16;  // integral carries 16 fraction bits
    localparam int OUT_SHIFT   = 24;  // Kp * bracket back to integer units
    localparam int EXCESS_W    = 32;  // saturation excess register
    localparam int BRACKET_W   = 48;  // bracket after clamping to +-2^46
    localparam int BRACKET_EXP = 46;

    typedef struct packed {
        logic [GAIN_W-1:0]  prop_gain;
        logic [GAIN_W-1:0]  integ_gain;
        logic [GAIN_W-1:0]  deriv_gain;
        logic [GAIN_W-1:0]  backcalc_gain;
        logic [GAIN_W-1:0]  sample_period;
        logic [LIMIT_W-1:0] out_limit;
    } cfg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_BC,
        ST_INTEG,
        ST_ISAT,
        ST_IG,
        ST_DG,
        ST_SUM,
        ST_PG,
        ST_RAW,
        ST_OUT
    } state_t;

    typedef enum logic [2:0] {
        MUL_BC,
        MUL_INT,
        MUL_IG,
        MUL_DG,
        MUL_PG
    } mul_op_t;

    typedef struct packed {
        logic    load_in;
        logic    mul_en;
        mul_op_t mul_op;
        logic    integ_upd;
        logic    acc_init;
        logic    s_load;
        logic    raw_load;
        logic    finish;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

// ----- sv/pidsr_cfg.sv -----
// Configuration register file of the PID speed regulator.
// Depends on pidsr_pkg for the register map and reset values.
module pidsr_cfg
    import pidsr_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            unique case (cfg_index)
                REG_PROP_GAIN:     cfg_next.prop_gain     = cfg_data;
                REG_INTEG_GAIN:    cfg_next.integ_gain    = cfg_data;
                REG_DERIV_GAIN:    cfg_next.deriv_gain    = cfg_data;
                REG_BACKCALC_GAIN: cfg_next.backcalc_gain = cfg_data;
                REG_SAMPLE_PERIOD: cfg_next.sample_period = cfg_data;
                REG_OUT_LIMIT:     cfg_next.out_limit     = cfg_data[LIMIT_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.prop_gain     <= RST_PROP_GAIN;
            cfg_reg.integ_gain    <= RST_INTEG_GAIN;
            cfg_reg.deriv_gain    <= RST_DERIV_GAIN;
            cfg_reg.backcalc_gain <= RST_BACKCALC_GAIN;
            cfg_reg.sample_period <= RST_SAMPLE_PERIOD;
            cfg_reg.out_limit     <= RST_OUT_LIMIT;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- sv/pidsr_ctrl.sv -----
// Sequencer of the PID speed regulator: steps the shared multiplier through
// the five products of one sample. Depends on pidsr_pkg.
module pidsr_ctrl
    import pidsr_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_ready,
    input  status_t status,
    output cmd_t    cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.mul_op = MUL_BC;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.load_in = in_valid;
                if (in_valid)
                begin
                    state_next = ST_BC;
                end
            end
            ST_BC:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_BC;
                state_next = ST_INTEG;
            end
            ST_INTEG:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_INT;
                state_next = ST_ISAT;
            end
            ST_ISAT:
            begin
                cmd.integ_upd = 1'b1;
                state_next    = ST_IG;
            end
            ST_IG:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_IG;
                state_next = ST_DG;
            end
            ST_DG:
            begin
                cmd.mul_en   = 1'b1;
                cmd.mul_op   = MUL_DG;
                cmd.acc_init = 1'b1;
                state_next   = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.s_load = 1'b1;
                state_next = ST_PG;
            end
            ST_PG:
            begin
                cmd.mul_en = 1'b1;
                cmd.mul_op = MUL_PG;
                state_next = ST_RAW;
            end
            ST_RAW:
            begin
                cmd.raw_load = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                // Hold here while the previous result still waits for its transfer.
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/pidsr_dp.sv -----
// Datapath of the PID speed regulator: error registers, one shared signed
// multiplier, integral and bracket accumulation, output clamp and result
// register. Depends on pidsr_pkg; driven by pidsr_ctrl commands.
module pidsr_dp
    import pidsr_pkg::*;
#(
    parameter int DATA_WIDTH     = 16,
    parameter int INTEGRAL_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  cfg_t                         cfg,
    input  cmd_t                         cmd,
    output status_t                      status,
    input  logic signed [DATA_WIDTH-1:0] speed_ref,
    input  logic signed [DATA_WIDTH-1:0] speed_meas,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] current_ref,
    output logic                         limited
);

    localparam int ERR_W   = DATA_WIDTH + 1;
    localparam int DERR_W  = DATA_WIDTH + 2;
    localparam int MUL_A_W = (INTEGRAL_WIDTH > BRACKET_W) ? INTEGRAL_WIDTH : BRACKET_W;
    localparam int MUL_B_W = GAIN_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 1;
    localparam int RAW_W   = PROD_W - OUT_SHIFT;
    localparam int DIFF_W  = RAW_W + 1;

    localparam logic signed [ACC_W-1:0] S_MAX =
        {{(ACC_W - BRACKET_EXP - 1){1'b0}}, 1'b1, {BRACKET_EXP{1'b0}}};
    localparam logic signed [ACC_W-1:0] S_MIN = -S_MAX;

    // State carried from sample to sample.
    logic signed [ERR_W-1:0]          prev_error_reg;
    logic signed [INTEGRAL_WIDTH-1:0] integral_reg;
    logic signed [INTEGRAL_WIDTH-1:0] integral_next;
    logic signed [EXCESS_W-1:0]       excess_reg;
    logic signed [EXCESS_W-1:0]       excess_next;
    logic                             out_valid_reg;

    // Working registers of one sample.
    logic signed [ERR_W-1:0]     e_reg;
    logic signed [DERR_W-1:0]    de_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    logic signed [ACC_W-1:0]     acc_reg;
    logic signed [BRACKET_W-1:0] s_reg;
    logic signed [BRACKET_W-1:0] s_next;
    logic signed [RAW_W-1:0]     raw_reg;
    logic signed [DATA_WIDTH-1:0] current_ref_reg;
    logic                         limited_reg;

    logic signed [ERR_W-1:0]   e_in;
    logic signed [DERR_W-1:0]  de_in;
    logic signed [MUL_A_W-1:0] bc_term;
    logic signed [MUL_A_W-1:0] mul_a;
    logic [GAIN_W-1:0]         mul_b;
    logic signed [PROD_W-1:0]  mul_p;
    logic signed [ACC_W-1:0]   isum;
    logic signed [ACC_W-1:0]   ssum;
    logic signed [ACC_W-1:0]   acc_init_val;
    logic [ACC_W-INTEGRAL_WIDTH:0] isum_top;
    logic signed [RAW_W-1:0]   lim;
    logic signed [RAW_W-1:0]   sat;
    logic                      clamped;
    logic signed [DIFF_W-1:0]  diff;
    logic [DIFF_W-EXCESS_W:0]  diff_top;

    assign e_in  = ERR_W'(speed_ref) - ERR_W'(speed_meas);
    assign de_in = DERR_W'(e_in) - DERR_W'(prev_error_reg);

    // Back-calculation term from the excess product.
    assign bc_term = MUL_A_W'(prod_reg >>> GAIN_FRAC);

    always_comb
    begin
        unique case (cmd.mul_op)
            MUL_BC:
            begin
                mul_a = MUL_A_W'(excess_reg);
                mul_b = cfg.backcalc_gain;
            end
            MUL_INT:
            begin
                mul_a = MUL_A_W'(e_reg) + bc_term;
                mul_b = cfg.sample_period;
            end
            MUL_IG:
            begin
                mul_a = MUL_A_W'(integral_reg);
                mul_b = cfg.integ_gain;
            end
            MUL_DG:
            begin
                mul_a = MUL_A_W'(de_reg);
                mul_b = cfg.deriv_gain;
            end
            MUL_PG:
            begin
                mul_a = MUL_A_W'(s_reg);
                mul_b = cfg.prop_gain;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * $signed({1'b0, mul_b});

    // Integral step with saturation at its own width.
    assign isum     = ACC_W'(integral_reg) + ACC_W'(prod_reg);
    assign isum_top = isum[ACC_W-1:INTEGRAL_WIDTH-1];

    always_comb
    begin
        if ((&isum_top) || !(|isum_top))
        begin
            integral_next = isum[INTEGRAL_WIDTH-1:0];
        end
        else if (isum[ACC_W-1])
        begin
            integral_next = {1'b1, {(INTEGRAL_WIDTH-1){1'b0}}};
        end
        else
        begin
            integral_next = {1'b0, {(INTEGRAL_WIDTH-1){1'b1}}};
        end
    end

    // Bracket: e in Q.12 plus the integral term, then the derivative term.
    assign acc_init_val = (ACC_W'(e_reg) <<< GAIN_FRAC) + ACC_W'(prod_reg >>> INTEG_FRAC);
    assign ssum         = acc_reg + ACC_W'(prod_reg);

    always_comb
    begin
        priority if (ssum > S_MAX)
        begin
            s_next = BRACKET_W'(S_MAX);
        end
        else if (ssum < S_MIN)
        begin
            s_next = BRACKET_W'(S_MIN);
        end
        else
        begin
            s_next = BRACKET_W'(ssum);
        end
    end

    // Symmetric output clamp and the excess kept for the next sample.
    assign lim = RAW_W'({1'b0, cfg.out_limit});

    always_comb
    begin
        priority if (raw_reg > lim)
        begin
            sat     = lim;
            clamped = 1'b1;
        end
        else if (raw_reg < -lim)
        begin
            sat     = -lim;
            clamped = 1'b1;
        end
        else
        begin
            sat     = raw_reg;
            clamped = 1'b0;
        end
    end

    assign diff     = DIFF_W'(sat) - DIFF_W'(raw_reg);
    assign diff_top = diff[DIFF_W-1:EXCESS_W-1];

    always_comb
    begin
        if ((&diff_top) || !(|diff_top))
        begin
            excess_next = diff[EXCESS_W-1:0];
        end
        else if (diff[DIFF_W-1])
        begin
            excess_next = {1'b1, {(EXCESS_W-1){1'b0}}};
        end
        else
        begin
            excess_next = {1'b0, {(EXCESS_W-1){1'b1}}};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_error_reg <= '0;
            integral_reg   <= '0;
            excess_reg     <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load_in)
            begin
                prev_error_reg <= e_in;
            end
            if (cmd.integ_upd)
            begin
                integral_reg <= integral_next;
            end
            if (cmd.finish)
            begin
                excess_reg    <= excess_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            e_reg  <= e_in;
            de_reg <= de_in;
        end
        if (cmd.mul_en)
        begin
            prod_reg <= mul_p;
        end
        if (cmd.acc_init)
        begin
            acc_reg <= acc_init_val;
        end
        if (cmd.s_load)
        begin
            s_reg <= s_next;
        end
        if (cmd.raw_load)
        begin
            raw_reg <= RAW_W'(prod_reg >>> OUT_SHIFT);
        end
        if (cmd.finish)
        begin
            current_ref_reg <= sat[DATA_WIDTH-1:0];
            limited_reg     <= clamped;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign current_ref     = current_ref_reg;
    assign limited         = limited_reg;

endmodule

// ----- sv/pid_speed_regulator_antiwindup_top.sv -----
// Top level of the PID speed regulator with back-calculation anti-windup.
// Depends on pidsr_pkg, pidsr_cfg, pidsr_ctrl and pidsr_dp.
//
// Usage:
//   Input channel (in_valid/in_ready, speed_ref, speed_meas) carries one control
//   sample per transfer. Output channel (out_valid/out_ready, current_ref,
//   limited) returns one clamped current reference per sample.
//   The configuration port writes one register per cycle with cfg_we high,
//   selected by cfg_index; write only while no sample is in flight.
// Sequence:
//   One shared multiplier forms five products in sequence, from ST_BC through to
//   ST_OUT; out_valid and in_ready then rise together in ST_IDLE, where the next
//   sample is taken. in_ready is high only between samples.
// Stall:
//   A finished result sits in an output register. A new sample is taken while it
//   waits; the following result holds in the last step, ST_OUT, until that
//   register is free.
// Reset:
//   rst_n clears the error history, integral and excess, loads the default
//   gains, sample period and output limit, and drops out_valid.
module pid_speed_regulator_antiwindup_top
    import pidsr_pkg::*;
#(
    parameter int DATA_WIDTH     = 16,
    parameter int INTEGRAL_WIDTH = 32
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [CFG_INDEX_W-1:0]       cfg_index,
    input  logic [CFG_DATA_W-1:0]        cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic signed [DATA_WIDTH-1:0] speed_ref,
    input  logic signed [DATA_WIDTH-1:0] speed_meas,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic signed [DATA_WIDTH-1:0] current_ref,
    output logic                         limited
);

    cfg_t    cfg;
    cmd_t    cmd;
    status_t status;

    pidsr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    pidsr_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .status   (status),
        .cmd      (cmd)
    );

    pidsr_dp #(
        .DATA_WIDTH     (DATA_WIDTH),
        .INTEGRAL_WIDTH (INTEGRAL_WIDTH)
    ) u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .cmd         (cmd),
        .status      (status),
        .speed_ref   (speed_ref),
        .speed_meas  (speed_meas),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .current_ref (current_ref),
        .limited     (limited)
    );

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for the PID speed regulator with back-calculation anti-windup.
// Depends on pidsr_pkg and pid_speed_regulator_antiwindup_top; it predicts every current
// reference in fixed point and checks it against the output channel.
module tb
    import pidsr_pkg::*;
();

    localparam int DATA_W       = 16;
    localparam int INTEG_W      = 32;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 12;
    localparam int IDLE_PCT     = 31;

    // Indexes past the register map; writes to them must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_6 = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_7 = 3'd7;

    localparam longint INTEG_MAX  = (longint'(1) << (INTEG_W - 1)) - 1;
    localparam longint INTEG_MIN  = -INTEG_MAX - 1;
    localparam longint EXCESS_MAX = (longint'(1) << (EXCESS_W - 1)) - 1;
    localparam longint EXCESS_MIN = -EXCESS_MAX - 1;
    localparam longint BRACKET_MAX = longint'(1) << BRACKET_EXP;

    typedef struct {
        logic signed [DATA_W-1:0] current_ref;
        logic                     limited;
    } drive_cmd_t;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_we = 1'b0;
    logic [CFG_INDEX_W-1:0]   cfg_index = REG_PROP_GAIN;
    logic [CFG_DATA_W-1:0]    cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic signed [DATA_W-1:0] speed_ref = '0;
    logic signed [DATA_W-1:0] speed_meas = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] current_ref;
    logic                     limited;

    // Shadow of the regulator's registers and state.
    cfg_t   cfg_model;
    longint last_error;
    longint error_integral;
    longint sat_excess;

    drive_cmd_t pending_drive_cmds[$];
    bit         steady_flow = 1'b0;
    int         mismatches = 0;
    int         samples_sent = 0;
    int         results_seen = 0;
    int         clamped_seen = 0;
    int         settings_used = 1;

    pid_speed_regulator_antiwindup_top #(
        .DATA_WIDTH     (DATA_W),
        .INTEGRAL_WIDTH (INTEG_W)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .speed_ref   (speed_ref),
        .speed_meas  (speed_meas),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .current_ref (current_ref),
        .limited     (limited)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic longint clamp_range(input longint x, input longint lo,
                                           input longint hi);
        if (x < lo)
            return lo;
        if (x > hi)
            return hi;
        return x;
    endfunction

    // One control step: error, anti-windup integral, PID bracket, clamp.
    function automatic drive_cmd_t regulate_step(input logic signed [DATA_W-1:0] sref,
                                                 input logic signed [DATA_W-1:0] smeas);
        longint err;
        longint derr;
        longint backcalc;
        longint bracket;
        longint raw;
        longint lim;
        longint sat;
        drive_cmd_t cmd;

        err = longint'(sref) - longint'(smeas);
        derr = err - last_error;
        last_error = err;

        backcalc = (sat_excess * longint'(cfg_model.backcalc_gain)) >>> GAIN_FRAC;
        error_integral = clamp_range(error_integral +
                                     (err + backcalc) * longint'(cfg_model.sample_period),
                                     INTEG_MIN, INTEG_MAX);

        bracket = err * (longint'(1) << GAIN_FRAC)
                + ((longint'(cfg_model.integ_gain) * error_integral) >>> INTEG_FRAC)
                + longint'(cfg_model.deriv_gain) * derr;
        bracket = clamp_range(bracket, -BRACKET_MAX, BRACKET_MAX);
        raw = (longint'(cfg_model.prop_gain) * bracket) >>> OUT_SHIFT;

        lim = longint'(cfg_model.out_limit);
        sat = clamp_range(raw, -lim, lim);
        cmd.limited = (sat != raw);
        cmd.current_ref = sat[DATA_W-1:0];
        sat_excess = clamp_range(sat - raw, EXCESS_MIN, EXCESS_MAX);
        return cmd;
    endfunction

    task automatic report_mismatch(input string field, input longint want, input longint got);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: result %0d, %s expected %0d, got %0d",
                     $time, results_seen, field, want, got);
    endtask

    // Output side: random back-pressure unless steady_flow is set, applied at the falling edge.
    always @(negedge clk)
    begin
        out_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk)
    begin
        drive_cmd_t want;
        if (rst_n && out_valid && out_ready)
        begin
            results_seen++;
            if (limited)
                clamped_seen++;
            if (pending_drive_cmds.size() == 0)
            begin
                report_mismatch("unexpected current_ref", 0, current_ref);
            end
            else
            begin
                want = pending_drive_cmds.pop_front();
                if (current_ref !== want.current_ref)
                    report_mismatch("current_ref", want.current_ref, current_ref);
                if (limited !== want.limited)
                    report_mismatch("limited", want.limited, limited);
            end
        end
    end

    // Offers one sample and records its prediction once the transfer happens.
    task automatic send_sample(input logic signed [DATA_W-1:0] sref,
                               input logic signed [DATA_W-1:0] smeas);
        @(negedge clk);
        while (!steady_flow && $urandom_range(0, 99) < IDLE_PCT)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        speed_ref <= sref;
        speed_meas <= smeas;
        do
            @(posedge clk);
        while (!in_ready);
        pending_drive_cmds.push_back(regulate_step(sref, smeas));
        samples_sent++;
    endtask

    // Registers may only change with nothing in flight.
    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_drive_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        @(negedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(negedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_PROP_GAIN:     cfg_model.prop_gain = value;
            REG_INTEG_GAIN:    cfg_model.integ_gain = value;
            REG_DERIV_GAIN:    cfg_model.deriv_gain = value;
            REG_BACKCALC_GAIN: cfg_model.backcalc_gain = value;
            REG_SAMPLE_PERIOD: cfg_model.sample_period = value;
            REG_OUT_LIMIT:     cfg_model.out_limit = value[LIMIT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input cfg_t c);
        wait_idle();
        write_reg(REG_PROP_GAIN, c.prop_gain);
        write_reg(REG_INTEG_GAIN, c.integ_gain);
        write_reg(REG_DERIV_GAIN, c.deriv_gain);
        write_reg(REG_BACKCALC_GAIN, c.backcalc_gain);
        write_reg(REG_SAMPLE_PERIOD, c.sample_period);
        write_reg(REG_OUT_LIMIT, {1'b0, c.out_limit});
        settings_used++;
    endtask

    function automatic logic [GAIN_W-1:0] random_gain();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2, 3: return GAIN_W'($urandom_range(0, 8192));
            default: return GAIN_W'($urandom);
        endcase
    endfunction

    function automatic cfg_t random_config();
        cfg_t c;
        c.prop_gain = random_gain();
        c.integ_gain = random_gain();
        c.deriv_gain = random_gain();
        c.backcalc_gain = random_gain();
        case ($urandom_range(0, 5))
            0: c.sample_period = '0;
            1: c.sample_period = '1;
            2, 3: c.sample_period = GAIN_W'($urandom_range(1, 2000));
            default: c.sample_period = GAIN_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: c.out_limit = '0;
            1: c.out_limit = '1;
            default: c.out_limit = LIMIT_W'($urandom_range(0, 32767));
        endcase
        return c;
    endfunction

    task automatic test_after_reset();
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd100, 16'sd0);
        send_sample(16'sd0, 16'sd100);
        send_sample(16'sd1000, -16'sd1000);
    endtask

    task automatic test_speed_extremes();
        send_sample(16'sh7FFF, 16'sh8000);
        send_sample(16'sh8000, 16'sh7FFF);
        send_sample(16'sh8000, 16'sh8000);
        send_sample(16'sh7FFF, 16'sh7FFF);
        send_sample(-16'sd1, 16'sd0);
    endtask

    task automatic test_zero_sample_period();
        wait_idle();
        write_reg(REG_SAMPLE_PERIOD, '0);
        send_sample(16'sd5000, 16'sd0);
        send_sample(-16'sd5000, 16'sd0);
        send_sample(16'sd123, -16'sd456);
    endtask

    // With no limit the output is pinned at zero and any nonzero drive is flagged.
    task automatic test_zero_current_limit();
        wait_idle();
        write_reg(REG_SAMPLE_PERIOD, RST_SAMPLE_PERIOD);
        write_reg(REG_OUT_LIMIT, '0);
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd20000, 16'sd0);
        send_sample(-16'sd20000, 16'sd0);
        send_sample(16'sd1, 16'sd0);
    endtask

    // Full-scale gains and period drive the integral into saturation both ways,
    // with large excess feeding the back-calculation path.
    task automatic test_integral_saturation();
        cfg_t c;
        c.prop_gain = '1;
        c.integ_gain = '1;
        c.deriv_gain = '1;
        c.backcalc_gain = '1;
        c.sample_period = '1;
        c.out_limit = '1;
        load_config(c);
        repeat (3) send_sample(16'sh7FFF, 16'sh8000);
        repeat (3) send_sample(16'sh8000, 16'sh7FFF);
    endtask

    // The top bit of the limit is dropped and spare indexes are ignored.
    task automatic test_register_decode();
        cfg_t c;
        c.prop_gain = RST_PROP_GAIN;
        c.integ_gain = RST_INTEG_GAIN;
        c.deriv_gain = RST_DERIV_GAIN;
        c.backcalc_gain = RST_BACKCALC_GAIN;
        c.sample_period = RST_SAMPLE_PERIOD;
        c.out_limit = RST_OUT_LIMIT;
        load_config(c);
        write_reg(REG_OUT_LIMIT, 16'h8000);
        write_reg(REG_SPARE_6, 16'hFFFF);
        write_reg(REG_SPARE_7, 16'h1234);
        send_sample(16'sd3000, 16'sd0);
        send_sample(-16'sd3000, 16'sd0);
    endtask

    // Mostly a held setpoint with the measurement scattered around it, plus
    // some fully random samples.
    task automatic test_random_regulation(input int count);
        int setpoint;
        int spread;
        int hold;
        int meas;
        hold = 0;
        setpoint = 0;
        spread = 16;
        for (int k = 0; k < count; k++)
        begin
            if (hold == 0)
            begin
                setpoint = int'($urandom_range(0, 65535)) - 32768;
                hold = $urandom_range(5, 40);
                case ($urandom_range(0, 3))
                    0: spread = 16;
                    1: spread = 512;
                    2: spread = 8192;
                    default: spread = 65535;
                endcase
            end
            hold--;
            if ($urandom_range(0, 9) == 0)
            begin
                send_sample(DATA_W'($urandom), DATA_W'($urandom));
            end
            else
            begin
                meas = setpoint + int'($urandom_range(0, 2 * spread)) - spread;
                meas = int'(clamp_range(meas, -32768, 32767));
                send_sample(DATA_W'(setpoint), DATA_W'(meas));
            end
        end
    endtask

    initial
    begin
        cfg_t c;

        cfg_model.prop_gain = RST_PROP_GAIN;
        cfg_model.integ_gain = RST_INTEG_GAIN;
        cfg_model.deriv_gain = RST_DERIV_GAIN;
        cfg_model.backcalc_gain = RST_BACKCALC_GAIN;
        cfg_model.sample_period = RST_SAMPLE_PERIOD;
        cfg_model.out_limit = RST_OUT_LIMIT;
        last_error = 0;
        error_integral = 0;
        sat_excess = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_after_reset();
        test_speed_extremes();
        test_zero_sample_period();
        test_zero_current_limit();
        test_integral_saturation();
        test_register_decode();

        c.prop_gain = RST_PROP_GAIN;
        c.integ_gain = RST_INTEG_GAIN;
        c.deriv_gain = RST_DERIV_GAIN;
        c.backcalc_gain = RST_BACKCALC_GAIN;
        c.sample_period = RST_SAMPLE_PERIOD;
        c.out_limit = RST_OUT_LIMIT;
        load_config(c);
        test_random_regulation(300);

        // Moderate gains with back-to-back transfers and no back-pressure.
        c.prop_gain = GAIN_W'($urandom_range(1024, 8192));
        c.integ_gain = GAIN_W'($urandom_range(0, 8192));
        c.deriv_gain = GAIN_W'($urandom_range(0, 4096));
        c.backcalc_gain = GAIN_W'($urandom_range(1024, 8192));
        c.sample_period = GAIN_W'($urandom_range(1, 500));
        c.out_limit = LIMIT_W'($urandom_range(1000, 20000));
        load_config(c);
        steady_flow = 1'b1;
        test_random_regulation(300);
        wait_idle();
        steady_flow = 1'b0;

        repeat (6)
        begin
            load_config(random_config());
            test_random_regulation(150);
        end

        c.prop_gain = '1;
        c.integ_gain = '1;
        c.deriv_gain = '1;
        c.backcalc_gain = '1;
        c.sample_period = '1;
        c.out_limit = '1;
        load_config(c);
        test_random_regulation(100);

        c.prop_gain = '0;
        c.integ_gain = '0;
        c.deriv_gain = '0;
        c.backcalc_gain = '0;
        c.sample_period = GAIN_W'(1);
        c.out_limit = '0;
        load_config(c);
        test_random_regulation(100);

        c.prop_gain = RST_PROP_GAIN;
        c.integ_gain = RST_INTEG_GAIN;
        c.deriv_gain = RST_DERIV_GAIN;
        c.backcalc_gain = RST_BACKCALC_GAIN;
        c.sample_period = RST_SAMPLE_PERIOD;
        c.out_limit = RST_OUT_LIMIT;
        load_config(c);
        test_random_regulation(100);

        wait_idle();
        if (pending_drive_cmds.size() != 0)
            mismatches += pending_drive_cmds.size();

        $display("Sent %0d speed samples under %0d register settings.",
                 samples_sent, settings_used);
        $display("Checked %0d current references, %0d of them clamped to the limit.",
                 results_seen, clamped_seen);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("Timed out waiting for the regulator.");
        $display("Mismatches found");
        $finish;
    end

endmodule

// ----- filelist.f -----
sv/pidsr_pkg.sv
sv/pidsr_cfg.sv
sv/pidsr_ctrl.sv
sv/pidsr_dp.sv
sv/pid_speed_regulator_antiwindup_top.sv
dv/tb.sv
